/* rtl/core/aes_pkg.sv */
package aes_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // round constants for rounds one to ten
    localparam t_byte RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // control handed from one cell to the next
    typedef struct packed {
        logic valid;
    } t_cell_ctrl;

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte get_byte(input t_block s, input int unsigned i);
        return s[127 - 8 * i -: 8];
    endfunction

    // subbytes and shiftrows, byte r + 4c is row r, column c
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] =
                    SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic t_block mix(input t_block s);
        t_block t;
        t_byte  a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4 * c);
            a1  = get_byte(s, 4 * c + 1);
            a2  = get_byte(s, 4 * c + 2);
            a3  = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1),
                                     a1 ^ all ^ xtime(a1 ^ a2),
                                     a2 ^ all ^ xtime(a2 ^ a3),
                                     a3 ^ all ^ xtime(a3 ^ a0)};
        end
        return t;
    endfunction

    // one step of the key schedule, four words at a time
    function automatic t_block next_key(input t_block k, input t_byte rc);
        logic [31:0] w3, t, n0, n1, n2, n3;
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

/* rtl/core/aes_pt_if.sv */
interface aes_pt_if;
    logic        valid;
    logic        ready;
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;

    modport source (output valid, output plaintext_high, output plaintext_low, input ready);
    modport sink   (input valid, input plaintext_high, input plaintext_low, output ready);
endinterface

/* rtl/core/aes_ct_if.sv */
interface aes_ct_if;
    logic        valid;
    logic        ready;
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;

    modport source (output valid, output ciphertext_high, output ciphertext_low, input ready);
    modport sink   (input valid, input ciphertext_high, input ciphertext_low, output ready);
endinterface

/* rtl/core/aes_round_cell.sv */
module aes_round_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_last,
    input  aes_pkg::t_byte          i_rcon,
    input  aes_pkg::t_cell_ctrl     i_ctrl,
    input  aes_pkg::t_block         i_state,
    input  aes_pkg::t_block         i_key,
    output aes_pkg::t_cell_ctrl     o_ctrl,
    output aes_pkg::t_block         o_state,
    output aes_pkg::t_block         o_key
);

    aes_pkg::t_cell_ctrl r_ctrl;
    aes_pkg::t_block     r_state, r_key;
    aes_pkg::t_block     n_state, n_key, w_sub;

    always_comb begin
        n_key   = aes_pkg::next_key(i_key, i_rcon);
        w_sub   = aes_pkg::sub_shift(i_state);
        n_state = (i_last ? w_sub : aes_pkg::mix(w_sub)) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

/* rtl/core/aes128_block_encrypt_core.sv */
// pipeline: key add plus ten round cells, each registered
// throughput: one block per cycle; the whole chain stalls only while the result is held
// reset: synchronous active-low; clears valid flags and both key registers to zero
// key registers must be written only while the chain is empty; the block itself does not enforce this
module aes128_block_encrypt_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    aes_pt_if.sink      i_pt,
    aes_ct_if.source    o_ct
);

    // key registers, index 0 is the high half
    logic [63:0] r_key_high, r_key_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx) begin
                r_key_low  <= i_cfg_data;
            end else begin
                r_key_high <= i_cfg_data;
            end
        end
    end

    // chain advances whenever the final cell is empty or its result is taken
    logic w_en;
    assign w_en       = !o_ct.valid || o_ct.ready;
    assign i_pt.ready = w_en;

    // cell 0: initial add of the cipher key
    aes_pkg::t_cell_ctrl w_ctrl  [aes_pkg::NumRounds + 1];
    aes_pkg::t_block     w_state [aes_pkg::NumRounds + 1];
    aes_pkg::t_block     w_key   [aes_pkg::NumRounds + 1];
    aes_pkg::t_cell_ctrl r_ctrl0;
    aes_pkg::t_block     r_state0, r_key0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl0 <= '0;
        end else if (w_en) begin
            r_ctrl0.valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_key0   <= {r_key_high, r_key_low};
            r_state0 <= {i_pt.plaintext_high, i_pt.plaintext_low}
                        ^ {r_key_high, r_key_low};
        end
    end

    assign w_ctrl[0]  = r_ctrl0;
    assign w_state[0] = r_state0;
    assign w_key[0]   = r_key0;

    // round cells; each derives its round key from the one before, key travels with the block
    for (genvar g = 0; g < aes_pkg::NumRounds; g++) begin : g_round
        aes_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_last  (g == aes_pkg::NumRounds - 1),
            .i_rcon  (aes_pkg::RCON[g]),
            .i_ctrl  (w_ctrl[g]),
            .i_state (w_state[g]),
            .i_key   (w_key[g]),
            .o_ctrl  (w_ctrl[g + 1]),
            .o_state (w_state[g + 1]),
            .o_key   (w_key[g + 1])
        );
    end

    // final cell register doubles as the output register
    assign o_ct.valid           = w_ctrl[aes_pkg::NumRounds].valid;
    assign o_ct.ciphertext_high = w_state[aes_pkg::NumRounds][127:64];
    assign o_ct.ciphertext_low  = w_state[aes_pkg::NumRounds][63:0];

endmodule

/* dv/tb_aes128_block_encrypt_core.sv */
module tb_aes128_block_encrypt_core;

    // register indexes of the key
    localparam logic KeyHighIdx = 1'b0;
    localparam logic KeyLowIdx  = 1'b1;
    localparam int   PipeDepth  = 11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = KeyHighIdx;
    logic [63:0] i_cfg_data = '0;

    aes_pt_if pt_bus ();
    aes_ct_if ct_bus ();

    aes128_block_encrypt_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_bus.sink),
        .o_ct       (ct_bus.source)
    );

    always #2 i_clk = ~i_clk;

    // independent cipher predictor, byte 0 at the top of the block
    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] encrypt_block_model(input logic [127:0] key,
                                                         input logic [127:0] pt);
        logic [7:0]  rk [176];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  w [4];
        logic [7:0]  f, rc, a0, a1, a2, a3, x;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) w[j] = rk[4 * (i - 1) + j];
            if (i % 4 == 0) begin
                f    = w[0];
                w[0] = aes_pkg::SBOX[w[1]] ^ rc;
                w[1] = aes_pkg::SBOX[w[2]];
                w[2] = aes_pkg::SBOX[w[3]];
                w[3] = aes_pkg::SBOX[f];
                rc   = gmul2(rc);
            end
            for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 4) + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r + 4 * c] = aes_pkg::SBOX[st[r + 4 * ((c + r) % 4)]];
            st = tmp;
            if (rnd != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4 * c]; a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ x ^ gmul2(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ x ^ gmul2(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ x ^ gmul2(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ x ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16 * rnd + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    // holds expected ciphertexts in order
    class cipher_scoreboard;
        logic [127:0] key;
        logic [127:0] pending [$];
        int           errors;

        function new();
            key = '0;
            errors = 0;
        endfunction

        function void note_plaintext(logic [127:0] pt);
            pending.push_back(encrypt_block_model(key, pt));
        endfunction

        function void check_ciphertext(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] exp_ct;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected ciphertext %h%h", hi, lo);
                return;
            end
            exp_ct = pending.pop_front();
            if (exp_ct[127:64] !== hi || exp_ct[63:0] !== lo) begin
                errors++;
                if (errors <= 10)
                    $display("ciphertext mismatch: exp %h act %h%h", exp_ct, hi, lo);
            end
        endfunction
    endclass

    cipher_scoreboard sb = new();

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  hold_cycles  = 0;
    bit  stim_done    = 1'b0;

    initial begin
        pt_bus.valid          = 1'b0;
        pt_bus.plaintext_high = '0;
        pt_bus.plaintext_low  = '0;
        ct_bus.ready          = 1'b0;
    end

    // sink side: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ct_bus.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            ct_bus.ready <= 1'b0;
        end else begin
            ct_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && ct_bus.valid && ct_bus.ready)
            sb.check_ciphertext(ct_bus.ciphertext_high, ct_bus.ciphertext_low);
    end

    // offer one block and wait for its transfer, idling at random first;
    // valid stays high afterwards so the next block can follow directly
    task automatic send_block(input logic [127:0] blk);
        while ($urandom_range(99) < src_idle_pct) begin
            pt_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_bus.valid          <= 1'b1;
        pt_bus.plaintext_high <= blk[127:64];
        pt_bus.plaintext_low  <= blk[63:0];
        do @(posedge i_clk); while (!pt_bus.ready);
        sb.note_plaintext(blk);
    endtask

    // drain the chain before touching the key
    task automatic wait_empty();
        pt_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PipeDepth + 2) @(posedge i_clk);
    endtask

    task automatic write_key_reg(input logic idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == KeyHighIdx) sb.key[127:64] = val;
        else sb.key[63:0] = val;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [127:0] rand_block();
        logic [127:0] b;
        case ($urandom_range(9))
            0: b = '0;
            1: b = '1;
            2: b = {rand64(), 64'h0};
            3: b = {64'h0, rand64()};
            4: b = 128'h1 << $urandom_range(127);
            default: b = {rand64(), rand64()};
        endcase
        return b;
    endfunction

    task automatic run_phase(input int n);
        for (int k = 0; k < n; k++) begin
            // idling pattern moves through three regimes
            if (k == n / 3) begin
                src_idle_pct = 54; snk_idle_pct = 36;
            end else if (k == 2 * n / 3) begin
                src_idle_pct = 0; snk_idle_pct = 0;
            end
            send_block(rand_block());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encrypting before any key write uses the all-zero key
        send_block('0);
        send_block('1);
        wait_empty();

        // standard test vector key
        write_key_reg(KeyHighIdx, 64'h0001020304050607);
        write_key_reg(KeyLowIdx,  64'h08090a0b0c0d0e0f);
        send_block(128'h00112233445566778899aabbccddeeff);
        send_block('0);
        send_block('1);
        send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001);
        wait_empty();

        // all-ones key
        write_key_reg(KeyHighIdx, '1);
        write_key_reg(KeyLowIdx,  '1);
        send_block('0);
        send_block('1);
        send_block(128'h00112233445566778899aabbccddeeff);

        // long receiver hold-off while the sender keeps offering, to fill the chain
        pt_bus.valid <= 1'b0;
        @(posedge i_clk);
        hold_cycles = 60;
        for (int k = 0; k < 20; k++) send_block(rand_block());
        wait_empty();

        // random keys with random traffic, idling shifts inside each phase
        src_idle_pct = 36; snk_idle_pct = 54;
        for (int p = 0; p < 4; p++) begin
            write_key_reg(KeyHighIdx, rand64());
            write_key_reg(KeyLowIdx,  rand64());
            src_idle_pct = 36; snk_idle_pct = 54;
            run_phase(240);
            wait_empty();
        end

        // back to zero key at the end
        write_key_reg(KeyHighIdx, '0);
        write_key_reg(KeyLowIdx,  '0);
        send_block(128'h0123456789abcdeffedcba9876543210);
        wait_empty();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
